// File: rtl/rbvq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relay bank value quantizer package
// Shared sizes, relay weights, operation codes, sequencer states and the
// result record handed from the search sequencer to the top level.
// ----------------------------------------------------------------------------
package rbvq_pkg;

	// Default sizes of the relay code and of the internal bank value.
	localparam int CODE_BITS_DEF  = 8;
	localparam int VALUE_BITS_DEF = 18;

	// Fixed widths of the stream fields.
	localparam int FIELD_CODE_W  = 8;
	localparam int FIELD_VALUE_W = 18;
	localparam int FIELD_OP_W    = 2;

	// Width of the raw bank sum, wide enough for any value size in range.
	localparam int SUM_BITS = 25;

	// Reset value of the error limit register, in quarter units.
	localparam logic [FIELD_VALUE_W-1:0] LIMIT_RESET = 18'd4000;

	// Base values of the two banks, in quarter units.
	localparam logic [SUM_BITS-1:0] L_BASE = 25'd200;
	localparam logic [SUM_BITS-1:0] C_BASE = 25'd100;

	// Operation codes carried in the input user field.
	typedef enum logic [FIELD_OP_W-1:0] {
		OP_L_CODE_TO_VALUE = 2'd0,
		OP_C_CODE_TO_VALUE = 2'd1,
		OP_L_VALUE_TO_CODE = 2'd2,
		OP_C_VALUE_TO_CODE = 2'd3
	} op_t;

	// Search sequencer states.
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_DRAIN  = 5'b00100,
		ST_TOTAL  = 5'b01000,
		ST_RESULT = 5'b10000
	} state_t;

	// Finished result offered by the sequencer.
	typedef struct packed {
		logic                     valid;
		logic [FIELD_CODE_W-1:0]  code;
		logic [FIELD_VALUE_W-1:0] total;
	} res_t;

	// Weight of one relay bit of the inductor or capacitor bank.
	function automatic logic [SUM_BITS-1:0] bit_weight(input logic cap,
							   input logic [2:0] idx);
		logic [SUM_BITS-1:0] w;
		if (cap) begin
			case (idx)
				3'd0:    w = 25'd100;
				3'd1:    w = 25'd200;
				3'd2:    w = 25'd356;
				3'd3:    w = 25'd660;
				3'd4:    w = 25'd1360;
				3'd5:    w = 25'd2400;
				3'd6:    w = 25'd4548;
				default: w = 25'd7756;
			endcase
		end else begin
			case (idx)
				3'd0:    w = 25'd750;
				3'd1:    w = 25'd1500;
				3'd2:    w = 25'd3000;
				3'd3:    w = 25'd6000;
				3'd4:    w = 25'd12000;
				3'd5:    w = 25'd24000;
				3'd6:    w = 25'd48000;
				default: w = 25'd96000;
			endcase
		end
		return w;
	endfunction

endpackage

// File: rtl/rbvq_bank_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank value unit
// Forms the total of one relay code (base plus the weight of every set bit),
// saturates it to the value width and registers it. Shared by the search
// and by the final total of the chosen code.
// ----------------------------------------------------------------------------
module rbvq_bank_unit #(
	parameter int CODE_BITS  = rbvq_pkg::CODE_BITS_DEF,
	parameter int VALUE_BITS = rbvq_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  cap,
	input  logic [CODE_BITS-1:0]  code,
	output logic [VALUE_BITS-1:0] value_s1
);

	localparam logic [rbvq_pkg::SUM_BITS-1:0] VMAX =
		rbvq_pkg::SUM_BITS'((64'd1 << VALUE_BITS) - 64'd1);

	logic [rbvq_pkg::SUM_BITS-1:0] sum;
	logic [rbvq_pkg::SUM_BITS-1:0] sat;

	// Sum the weights of the set relay bits on top of the bank base.
	always_comb begin
		sum = cap ? rbvq_pkg::C_BASE : rbvq_pkg::L_BASE;
		for (int b = 0; b < CODE_BITS; b++) begin
			if (code[b]) begin
				sum = sum + rbvq_pkg::bit_weight(cap, 3'(b));
			end
		end
		sat = (sum > VMAX) ? VMAX : sum;
	end

	// Register the total for the compare stage.
	always_ff @(posedge clk) begin
		value_s1 <= sat[VALUE_BITS-1:0];
	end

endmodule

// File: rtl/rbvq_search_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Search sequencer
// Takes one transaction, steps the bank value unit through every code for a
// value-to-code search keeping the nearest total whose error is below the error
// limit, then reads the total of the chosen code and offers the result.
// ----------------------------------------------------------------------------
module rbvq_search_ctrl #(
	parameter int CODE_BITS  = rbvq_pkg::CODE_BITS_DEF,
	parameter int VALUE_BITS = rbvq_pkg::VALUE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  rbvq_pkg::op_t                       in_op,
	input  logic [rbvq_pkg::FIELD_CODE_W-1:0]   in_code,
	input  logic [rbvq_pkg::FIELD_VALUE_W-1:0]  in_target,
	input  logic [rbvq_pkg::FIELD_VALUE_W-1:0]  error_limit,
	output logic                                unit_cap,
	output logic [CODE_BITS-1:0]                unit_code,
	input  logic [VALUE_BITS-1:0]               unit_value,
	output rbvq_pkg::res_t                      res,
	input  logic                                res_ready
);

	// Error width covers both the bank value and the target.
	localparam int EW = (VALUE_BITS > rbvq_pkg::FIELD_VALUE_W) ?
		VALUE_BITS : rbvq_pkg::FIELD_VALUE_W;

	rbvq_pkg::state_t state_q;
	rbvq_pkg::op_t    op_q;
	logic [CODE_BITS-1:0] cnt_q;
	logic [CODE_BITS-1:0] cnt_s1;
	logic                 val_s1;
	logic [rbvq_pkg::FIELD_VALUE_W-1:0] target_q;
	logic [CODE_BITS-1:0] best_code_q;
	logic [EW-1:0]        best_err_q;

	logic          search;
	logic [EW-1:0] value_ext;
	logic [EW-1:0] target_ext;
	logic [EW-1:0] err;

	assign search = (in_op == rbvq_pkg::OP_L_VALUE_TO_CODE) ||
			(in_op == rbvq_pkg::OP_C_VALUE_TO_CODE);

	// Drive the shared unit: the running code while scanning, else the chosen one.
	assign unit_cap  = (op_q == rbvq_pkg::OP_C_CODE_TO_VALUE) ||
			   (op_q == rbvq_pkg::OP_C_VALUE_TO_CODE);
	assign unit_code = (state_q == rbvq_pkg::ST_SCAN) ? cnt_q : best_code_q;
	assign in_ready  = (state_q == rbvq_pkg::ST_IDLE);

	// Absolute error of the registered total against the target.
	always_comb begin
		value_ext  = EW'(unit_value);
		target_ext = EW'(target_q);
		err = (value_ext >= target_ext) ? (value_ext - target_ext) :
						   (target_ext - value_ext);
	end

	// Result record towards the output register.
	always_comb begin
		res.valid = (state_q == rbvq_pkg::ST_RESULT);
		res.code  = rbvq_pkg::FIELD_CODE_W'(best_code_q);
		res.total = value_ext[rbvq_pkg::FIELD_VALUE_W-1:0];
	end

	// Sequencer state and compare-stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rbvq_pkg::ST_IDLE;
			val_s1  <= 1'b0;
		end else begin
			val_s1 <= (state_q == rbvq_pkg::ST_SCAN);
			case (state_q)
				rbvq_pkg::ST_IDLE: begin
					if (in_valid) begin
						state_q <= search ? rbvq_pkg::ST_SCAN :
								    rbvq_pkg::ST_TOTAL;
					end
				end
				rbvq_pkg::ST_SCAN: begin
					if (cnt_q == {CODE_BITS{1'b1}}) begin
						state_q <= rbvq_pkg::ST_DRAIN;
					end
				end
				rbvq_pkg::ST_DRAIN:  state_q <= rbvq_pkg::ST_TOTAL;
				rbvq_pkg::ST_TOTAL:  state_q <= rbvq_pkg::ST_RESULT;
				rbvq_pkg::ST_RESULT: begin
					if (res_ready) begin
						state_q <= rbvq_pkg::ST_IDLE;
					end
				end
				default: state_q <= rbvq_pkg::ST_IDLE;
			endcase
		end
	end

	// Item capture, scan counter and best-code tracking.
	always_ff @(posedge clk) begin
		cnt_s1 <= cnt_q;
		if (state_q == rbvq_pkg::ST_IDLE && in_valid) begin
			op_q     <= in_op;
			target_q <= in_target;
			cnt_q    <= '0;
			if (search) begin
				best_code_q <= '0;
				best_err_q  <= EW'(error_limit);
			end else begin
				best_code_q <= in_code[CODE_BITS-1:0];
			end
		end
		if (state_q == rbvq_pkg::ST_SCAN) begin
			cnt_q <= cnt_q + 1'b1;
		end
		// Strictly smaller error wins, so ties keep the lower code.
		if (val_s1 && (err < best_err_q)) begin
			best_err_q  <= err;
			best_code_q <= cnt_s1;
		end
	end

endmodule

// File: rtl/relay_bank_value_quantizer_core.sv
`timescale 1ns / 1ps
// A value-to-code search steps through all 2^CODE_BITS codes (256 by default),
// one code per cycle through the shared bank value unit, before the total of the
// chosen code is read; a code-to-value transaction reads that total directly.
// One transaction at a time: the input is ready again once the
// result has moved to the output register. Reset is asynchronous, active low,
// and leaves the block idle with the error limit at 4000 quarter units.
// ----------------------------------------------------------------------------
// Relay bank value quantizer
// Converts between an 8-bit relay code and the total value of the inductor
// or capacitor bank, or searches for the code whose total is nearest a target.
// ----------------------------------------------------------------------------
module relay_bank_value_quantizer_core #(
	parameter int CODE_BITS  = rbvq_pkg::CODE_BITS_DEF,
	parameter int VALUE_BITS = rbvq_pkg::VALUE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [17:0] cfg_wdata,   // error_limit
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,     // relay_code [7:0], target_value [25:8], zeros
	input  logic [1:0]  s_tuser,     // operation [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata      // code_out [7:0], bank_total [25:8], zeros
);

	logic [rbvq_pkg::FIELD_VALUE_W-1:0] error_limit_q;
	logic                  unit_cap;
	logic [CODE_BITS-1:0]  unit_code;
	logic [VALUE_BITS-1:0] unit_value;
	rbvq_pkg::res_t        res;
	logic                  res_ready;
	logic                                out_valid_q;
	logic [rbvq_pkg::FIELD_CODE_W-1:0]  out_code_q;
	logic [rbvq_pkg::FIELD_VALUE_W-1:0] out_total_q;

	// Error limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_limit_q <= rbvq_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			error_limit_q <= cfg_wdata;
		end
	end

	rbvq_search_ctrl #(
		.CODE_BITS  (CODE_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_op       (rbvq_pkg::op_t'(s_tuser)),
		.in_code     (s_tdata[7:0]),
		.in_target   (s_tdata[25:8]),
		.error_limit (error_limit_q),
		.unit_cap    (unit_cap),
		.unit_code   (unit_code),
		.unit_value  (unit_value),
		.res         (res),
		.res_ready   (res_ready)
	);

	rbvq_bank_unit #(
		.CODE_BITS  (CODE_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_unit (
		.clk      (clk),
		.cap      (unit_cap),
		.code     (unit_code),
		.value_s1 (unit_value)
	);

	// Output register: takes a result whenever it is empty or being drained.
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			out_code_q  <= res.code;
			out_total_q <= res.total;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_total_q, out_code_q};

	// An accepted transaction makes the block busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input still ready after a transaction was taken");

	// An idle sequencer offers no result.
	a_idle_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !res.valid)
		else $error("result offered while the sequencer is idle");

	// A result that is held back stays put until the output register takes it.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res_ready |=> res.valid && $stable(res.code) &&
			$stable(res.total))
		else $error("pending result changed before hand-over");

endmodule
